### rtl/tlcg_pkg.sv
`timescale 1ns / 1ps
// Package for the text line character generator.
// Item types, store geometry and derived widths; no dependencies.
package tlcg_pkg;

  localparam int TEXT_COLUMNS = 32;
  localparam int TEXT_ROWS    = 16;
  localparam int GLYPH_HEIGHT = 18;
  localparam int GLYPH_COUNT  = 256;

  localparam int CELL_COUNT  = TEXT_ROWS * TEXT_COLUMNS;
  localparam int PLANE_WORDS = GLYPH_HEIGHT * GLYPH_COUNT;

  localparam int CELL_AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int FONT_AW = (PLANE_WORDS > 1) ? $clog2(PLANE_WORDS) : 1;
  localparam int COL_W   = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
  localparam int FROW_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  // Half line number, and its division by the glyph height via a reciprocal
  localparam int HALF_W  = 9;
  localparam int RECIP_W = 17;
  localparam int DIV_SH  = 16;
  localparam int RECIP   = (1 << DIV_SH) / GLYPH_HEIGHT;
  localparam int DIV_PW  = HALF_W + RECIP_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [1:0] OP_CELL   = 2'd0;
  localparam logic [1:0] OP_FONT   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  line_number;
    logic [3:0]  cell_row;
    logic [4:0]  cell_column;
    logic [7:0]  glyph_code;
    logic        font_plane;
    logic [4:0]  glyph_row;
    logic [15:0] font_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] white_bits;
    logic [15:0] black_bits;
    logic [4:0]  column_index;
    logic        last_column;
  } out_item_t;

endpackage

### rtl/text_line_character_generator.sv
`timescale 1ns / 1ps
// On-screen-display text line generator: cell store, two font planes, render engine.
// Depends on tlcg_pkg and tlcg_ram.
//
// After reset the block clears the character cell memory and takes no item
// meanwhile. A write item (cell or font word) leaves the block idle, so the
// next item can follow straight after it. A render item steps through S_DIV,
// S_FIX and S_BASE to split the line into text row and glyph row, then issues
// one column per cycle while the result queue has credit into a two-stage read
// pipeline (cell memory, then font memory) feeding a four-entry result queue,
// paced by the single read port of each memory. A following item is taken once
// the last column has left the cell read stage; results keep draining meanwhile.
module text_line_character_generator
  import tlcg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_FIX   = 6'b001000,
    S_BASE  = 6'b010000,
    S_ISSUE = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CELL_AW-1:0] clr_addr;
  logic [HALF_W-1:0]  half;
  logic [HALF_W-1:0]  quot;
  logic [HALF_W-1:0]  trow;
  logic [FROW_W-1:0]  frow;
  logic [CELL_AW-1:0] cell_base;
  logic               in_text;
  logic [COL_W-1:0]   col;

  logic               s1_valid, s1_zero, s1_last;
  logic [COL_W-1:0]   s1_col;
  logic               s2_valid, s2_zero, s2_last;
  logic [COL_W-1:0]   s2_col;

  out_item_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] fifo_count;
  logic [FIFO_CW-1:0] held;

  logic               accept, issue, pop, col_last;
  logic               cell_we, white_we, black_we, font_ok;
  logic [CELL_AW-1:0] cell_waddr, cell_raddr;
  logic [7:0]         cell_wdata, cell_rdata;
  logic [FONT_AW-1:0] font_waddr, font_raddr;
  logic [15:0]        white_rdata, black_rdata;
  logic [DIV_PW-1:0]  div_prod;
  logic [HALF_W-1:0]  rem_raw;
  logic               code_bad;

  function automatic logic [4:0] col_out(input logic [COL_W-1:0] c);
    logic [COL_W+4:0] t;
    t = {5'b0, c};
    return t[4:0];
  endfunction

  assign accept     = item_valid && item_ready;
  assign item_ready = (state == S_IDLE) && !s1_valid;
  assign col_last   = (col == COL_W'(TEXT_COLUMNS - 1));
  assign issue      = (state == S_ISSUE) && (held < FIFO_CW'(FIFO_DEPTH));
  assign pop        = result_valid && result_ready;

  // Write side of the memories
  assign font_ok = (item.glyph_row < 5'(GLYPH_HEIGHT)) &&
                   ({1'b0, item.glyph_code} < 9'(GLYPH_COUNT));
  assign font_waddr = FONT_AW'(32'(item.glyph_row) * 32'(GLYPH_COUNT) + 32'(item.glyph_code));
  assign white_we   = accept && (item.op == OP_FONT) && font_ok && !item.font_plane;
  assign black_we   = accept && (item.op == OP_FONT) && font_ok && item.font_plane;

  always_comb begin
    if (state == S_CLEAR) begin
      cell_we    = 1'b1;
      cell_waddr = clr_addr;
      cell_wdata = '0;
    end else begin
      cell_we    = accept && (item.op == OP_CELL) &&
                   ({1'b0, item.cell_row} < 5'(TEXT_ROWS)) &&
                   ({1'b0, item.cell_column} < 6'(TEXT_COLUMNS));
      cell_waddr = CELL_AW'(32'(item.cell_row) * 32'(TEXT_COLUMNS) + 32'(item.cell_column));
      cell_wdata = item.glyph_code;
    end
  end

  // Read side
  assign cell_raddr = cell_base + CELL_AW'(col);
  assign font_raddr = FONT_AW'(32'(frow) * 32'(GLYPH_COUNT) + 32'(cell_rdata));
  assign code_bad   = ({1'b0, cell_rdata} >= 9'(GLYPH_COUNT));

  tlcg_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_cells (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_waddr),
    .wr_data (cell_wdata),
    .rd_en   (issue),
    .rd_addr (cell_raddr),
    .rd_data (cell_rdata)
  );

  tlcg_ram #(.WIDTH(16), .DEPTH(PLANE_WORDS)) u_white (
    .clk     (clk),
    .wr_en   (white_we),
    .wr_addr (font_waddr),
    .wr_data (item.font_word),
    .rd_en   (s1_valid),
    .rd_addr (font_raddr),
    .rd_data (white_rdata)
  );

  tlcg_ram #(.WIDTH(16), .DEPTH(PLANE_WORDS)) u_black (
    .clk     (clk),
    .wr_en   (black_we),
    .wr_addr (font_waddr),
    .wr_data (item.font_word),
    .rd_en   (s1_valid),
    .rd_addr (font_raddr),
    .rd_data (black_rdata)
  );

  // Line split: quotient estimate, then one correction step
  assign div_prod = DIV_PW'(half) * DIV_PW'(RECIP);
  assign rem_raw  = half - HALF_W'(32'(quot) * 32'(GLYPH_HEIGHT));

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == CELL_AW'(CELL_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept && (item.op == OP_RENDER)) state_next = S_DIV;
      S_DIV:   state_next = S_FIX;
      S_FIX:   state_next = S_BASE;
      S_BASE:  state_next = S_ISSUE;
      S_ISSUE: if (issue && col_last) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      col        <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      held       <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_BASE) begin
        col <= '0;
      end else if (issue) begin
        col <= col + 1'b1;
      end
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + FIFO_CW'(s2_valid) - FIFO_CW'(pop);
      held       <= held + FIFO_CW'(issue) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      half <= item.line_number[9:1];
    end
    if (state == S_DIV) begin
      quot <= HALF_W'(div_prod >> DIV_SH);
    end
    if (state == S_FIX) begin
      if (rem_raw >= HALF_W'(GLYPH_HEIGHT)) begin
        trow <= quot + 1'b1;
        frow <= FROW_W'(rem_raw - HALF_W'(GLYPH_HEIGHT));
      end else begin
        trow <= quot;
        frow <= FROW_W'(rem_raw);
      end
    end
    if (state == S_BASE) begin
      in_text   <= (trow < HALF_W'(TEXT_ROWS));
      cell_base <= CELL_AW'(32'(trow) * 32'(TEXT_COLUMNS));
    end
    s1_col  <= col;
    s1_last <= col_last;
    s1_zero <= !in_text;
    s2_col  <= s1_col;
    s2_last <= s1_last;
    s2_zero <= s1_zero || code_bad;
    if (s2_valid) begin
      fifo_mem[wr_ptr].white_bits   <= s2_zero ? 16'h0 : white_rdata;
      fifo_mem[wr_ptr].black_bits   <= s2_zero ? 16'h0 : black_rdata;
      fifo_mem[wr_ptr].column_index <= col_out(s2_col);
      fifo_mem[wr_ptr].last_column  <= s2_last;
    end
  end

  assign result_valid = (fifo_count != '0);
  assign result       = fifo_mem[rd_ptr];

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    held <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue credit exceeds its depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= held)
    else $error("result queue holds more items than were issued");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> fifo_count != FIFO_CW'(FIFO_DEPTH))
    else $error("font read arrives at a full result queue");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !item_ready)
    else $error("item taken during cell clearing");

endmodule

### rtl/tlcg_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tlcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### dv/text_line_character_generator_tb.sv
`timescale 1ns / 1ps
// Testbench for text_line_character_generator: random cell, font and render items,
// checked column by column against a local model of the cell and font stores.
// Depends on tlcg_pkg and the block's RTL.
module text_line_character_generator_tb;
  import tlcg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS = 410;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER  = 600;
  localparam int HOLD_CYCLES = 400;

  class column_ledger;
    logic [7:0]  cells [CELL_COUNT];
    logic [15:0] font_bits [2][GLYPH_HEIGHT][GLYPH_COUNT];
    bit          font_set [2][GLYPH_HEIGHT][GLYPH_COUNT];
    out_item_t   columns_due [$];
    int          mismatches;

    function new();
      foreach (cells[i]) cells[i] = 8'h00;
      foreach (font_set[p, r, g]) font_set[p][r][g] = 1'b0;
      mismatches = 0;
    endfunction

    function void note_item(in_item_t it);
      int half;
      int trow;
      int frow;
      int g;
      out_item_t col;
      case (it.op)
        OP_CELL: begin
          if (it.cell_row < TEXT_ROWS && it.cell_column < TEXT_COLUMNS)
            cells[it.cell_row * TEXT_COLUMNS + it.cell_column] = it.glyph_code;
        end
        OP_FONT: begin
          if (it.glyph_row < GLYPH_HEIGHT && it.glyph_code < GLYPH_COUNT) begin
            font_bits[it.font_plane][it.glyph_row][it.glyph_code] = it.font_word;
            font_set[it.font_plane][it.glyph_row][it.glyph_code] = 1'b1;
          end
        end
        OP_RENDER: begin
          half = it.line_number >> 1;
          trow = half / GLYPH_HEIGHT;
          frow = half % GLYPH_HEIGHT;
          for (int c = 0; c < TEXT_COLUMNS; c++) begin
            col.white_bits   = 16'h0000;
            col.black_bits   = 16'h0000;
            col.column_index = c[4:0];
            col.last_column  = (c == TEXT_COLUMNS - 1);
            if (trow < TEXT_ROWS) begin
              g = cells[trow * TEXT_COLUMNS + c];
              if (g < GLYPH_COUNT) begin
                col.white_bits = font_bits[0][frow][g];
                col.black_bits = font_bits[1][frow][g];
              end
            end
            columns_due.push_back(col);
          end
        end
        default: ;
      endcase
    endfunction

    // Finds a font word that rendering this line would read but that was never written
    function bit unwritten_word(input logic [9:0] line, output int plane, output int row,
                                output int glyph);
      int half;
      int trow;
      half = line >> 1;
      trow = half / GLYPH_HEIGHT;
      row  = half % GLYPH_HEIGHT;
      if (trow >= TEXT_ROWS) return 1'b0;
      for (int c = 0; c < TEXT_COLUMNS; c++) begin
        glyph = cells[trow * TEXT_COLUMNS + c];
        for (int p = 0; p < 2; p++) begin
          if (glyph < GLYPH_COUNT && !font_set[p][row][glyph]) begin
            plane = p;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void check_column(out_item_t got);
      out_item_t want;
      if (columns_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected column: white %h black %h col %0d last %b",
                   got.white_bits, got.black_bits, got.column_index, got.last_column);
        return;
      end
      want = columns_due.pop_front();
      if (got.white_bits !== want.white_bits || got.black_bits !== want.black_bits ||
          got.column_index !== want.column_index || got.last_column !== want.last_column)
      begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("column mismatch: want white %h black %h col %0d last %b, ",
                 want.white_bits, want.black_bits, want.column_index, want.last_column);
          $display("got white %h black %h col %0d last %b",
                   got.white_bits, got.black_bits, got.column_index, got.last_column);
        end
      end
    endfunction

    function int outstanding();
      return columns_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;

  column_ledger ledger;
  int  cycles;
  int  sent;
  int  renders;
  int  checked;
  int  hold_left;
  bit  held;
  bit  calm;

  text_line_character_generator dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("text_line_character_generator_tb failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        ledger.check_column(result);
        checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (!held && checked >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic in_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [7:0] pick_glyph();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(7));
  endfunction

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99) < 33) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    ledger.note_item(it);
    sent++;
  endtask

  task automatic write_cell(input int row, input int column, input logic [7:0] code);
    in_item_t it;
    it = noise_item();
    it.op = OP_CELL;
    it.cell_row = 4'(row);
    it.cell_column = 5'(column);
    it.glyph_code = code;
    send_item(it);
  endtask

  task automatic write_font(input int plane, input int row, input logic [7:0] glyph,
                            input logic [15:0] word);
    in_item_t it;
    it = noise_item();
    it.op = OP_FONT;
    it.font_plane = 1'(plane);
    it.glyph_row = 5'(row);
    it.glyph_code = glyph;
    it.font_word = word;
    send_item(it);
  endtask

  // Every font word the line will read is written first
  task automatic render_line(input logic [9:0] line);
    in_item_t it;
    int p;
    int r;
    int g;
    while (ledger.unwritten_word(line, p, r, g))
      write_font(p, r, g[7:0], 16'($urandom_range(16'hFFFF)));
    it = noise_item();
    it.op = OP_RENDER;
    it.line_number = line;
    send_item(it);
    renders++;
  endtask

  initial begin
    in_item_t it;
    int pick;
    ledger = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: rows past the buffer, ignored items, extreme words and cells
    render_line(10'd1023);
    render_line(10'd576);
    it = '1;
    it.op = OP_UNUSED;
    send_item(it);
    write_font(0, 18, 8'd0, 16'hFFFF);
    write_font(1, 31, 8'd255, 16'hFFFF);
    write_font(0, 0, 8'd255, 16'hFFFF);
    write_font(1, 0, 8'd255, 16'h0000);
    write_font(0, 17, 8'd0, 16'h8001);
    write_font(1, 17, 8'd0, 16'h7FFE);
    write_cell(0, 0, 8'd255);
    write_cell(15, 31, 8'd255);
    write_cell(15, 0, 8'd0);
    render_line(10'd0);
    render_line(10'd1);
    render_line(10'd575);
    render_line(10'd574);

    while (sent < TOTAL_ITEMS) begin
      calm = (sent >= 150 && sent < 230);
      pick = $urandom_range(99);
      if (pick < 38) begin
        if ($urandom_range(9) < 6) render_line(10'($urandom_range(575)));
        else render_line(10'($urandom_range(1023)));
      end else if (pick < 68) begin
        write_cell($urandom_range(15), $urandom_range(31), pick_glyph());
      end else if (pick < 94) begin
        if ($urandom_range(9) == 0)
          write_font($urandom_range(1), $urandom_range(31, 18), pick_glyph(), 16'($urandom));
        else
          write_font($urandom_range(1), $urandom_range(17), pick_glyph(), 16'($urandom));
      end else begin
        it = noise_item();
        it.op = OP_UNUSED;
        send_item(it);
      end
    end
    calm = 1'b0;
    item_valid <= 1'b0;

    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (ledger.outstanding() != 0) ledger.mismatches += ledger.outstanding();

    $display("%0d items sent, %0d of them line renders; %0d columns checked",
             sent, renders, checked);
    $display("covered rows past the buffer, ignored writes, one long result hold-off");
    if (ledger.mismatches == 0) begin
      $display("text_line_character_generator_tb passed");
    end else begin
      $display("%0d mismatches", ledger.mismatches);
      $display("text_line_character_generator_tb failed");
    end
    $finish;
  end

endmodule
